### src/cgsr_pkg.sv
package cgsr_pkg;

	// access kinds
	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// port register selects
	localparam logic [1:0] SEL_DATA   = 2'd0;
	localparam logic [1:0] SEL_DIR    = 2'd1;
	localparam logic [1:0] SEL_RDEN   = 2'd2;
	localparam logic [1:0] SEL_UNUSED = 2'd3;

	// configuration register indexes
	localparam logic CFG_CLOCK_EN  = 1'b0;
	localparam logic CFG_RUMBLE_EN = 1'b1;

	// direction patterns that select a sensor
	localparam logic [7:0] DIR_LIGHT = 8'h07;
	localparam logic [7:0] DIR_TILT  = 8'h0b;

	// clock commands
	localparam logic [7:0] CMD_RESET    = 8'h60;
	localparam logic [7:0] CMD_WRITE    = 8'h62;
	localparam logic [7:0] CMD_STATUS   = 8'h63;
	localparam logic [7:0] CMD_CONTINUE = 8'h64;
	localparam logic [7:0] CMD_DATETIME = 8'h65;
	localparam logic [7:0] CMD_TIME     = 8'h67;

	localparam logic [7:0]  STATUS_BYTE  = 8'h40;
	localparam logic [15:0] TILT_OFFSET  = 16'h06c0;
	localparam logic [15:0] CMD_START    = 16'h0005;

	typedef enum logic [3:0] {
		PH_IDLE = 4'b0001,
		PH_CMD  = 4'b0010,
		PH_SEND = 4'b0100,
		PH_RECV = 4'b1000
	} phase_t;

	typedef struct packed {
		logic        op;
		logic [1:0]  reg_select;
		logic [15:0] write_value;
		logic [7:0]  light_level;
		logic [15:0] tilt_z;
		logic [7:0]  time_year;
		logic [3:0]  time_month;
		logic [4:0]  time_day;
		logic [2:0]  time_weekday;
		logic [4:0]  time_hour;
		logic [5:0]  time_minute;
		logic [5:0]  time_second;
	} item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       rumble_update;
		logic       rumble_on;
	} result_t;

	// binary 0..255 to two BCD digits of (v mod 100)
	function automatic logic [7:0] bcd8(input logic [7:0] v);
		logic [6:0]  r;
		logic [14:0] prod;
		logic [3:0]  tens;
		logic [6:0]  ones;
		if (v >= 8'd200) begin
			r = 7'(v - 8'd200);
		end else if (v >= 8'd100) begin
			r = 7'(v - 8'd100);
		end else begin
			r = v[6:0];
		end
		prod = 15'(r) * 15'd205;
		tens = prod[14:11];
		ones = r - 7'(tens) * 7'd10;
		return {tens, ones[3:0]};
	endfunction

endpackage

### src/cartridge_gpio_serial_rtc_unit.sv
// Cartridge GPIO port with serial clock, light and tilt sensors. Each item is
// one bus access to the data, direction or read-enable register; each gives
// exactly one result item carrying read data (zero for writes) and a rumble
// motor update. Items flow back to back: one item per cycle is accepted while
// the result side is not stalled by out_ready; each item is held in an input
// register and then moves on into an output register that holds its result.
// The input register and the output register let the block take
// a new item while a finished result still waits for out_ready. The port
// state (pins, direction, read enable, serial clock command and shift buffer,
// sensor counter) advances when an item moves from the input register to the
// output register. Configuration writes (clock_enable, rumble_enable) are
// taken at any edge with cfg_we high and should be issued only while idle.
module cartridge_gpio_serial_rtc_unit
	import cgsr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic        cfg_data,
	// input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        op,
	input  logic [1:0]  reg_select,
	input  logic [15:0] write_value,
	input  logic [7:0]  light_level,
	input  logic [15:0] tilt_z,
	input  logic [7:0]  time_year,
	input  logic [3:0]  time_month,
	input  logic [4:0]  time_day,
	input  logic [2:0]  time_weekday,
	input  logic [4:0]  time_hour,
	input  logic [5:0]  time_minute,
	input  logic [5:0]  time_second,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  read_data,
	output logic        rumble_update,
	output logic        rumble_on
);

	logic    clock_en_q, rumble_en_q;
	logic    valid_s1;
	item_t   item_s1;
	logic    out_valid_q;
	result_t res_q;
	result_t res_d;
	logic    advance;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_en_q  <= 1'b1;
			rumble_en_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CLOCK_EN:  clock_en_q  <= cfg_data;
				CFG_RUMBLE_EN: rumble_en_q <= cfg_data;
				default:       clock_en_q  <= clock_en_q;
			endcase
		end
	end

	// move the held item into the result register when that slot frees up
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload of the input register: hold while stalled
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= '{op: op, reg_select: reg_select, write_value: write_value,
				light_level: light_level, tilt_z: tilt_z, time_year: time_year,
				time_month: time_month, time_day: time_day,
				time_weekday: time_weekday, time_hour: time_hour,
				time_minute: time_minute, time_second: time_second};
		end
	end

	cgsr_port_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.clock_enable  (clock_en_q),
		.rumble_enable (rumble_en_q),
		.advance       (advance),
		.item          (item_s1),
		.result        (res_d)
	);

	// result register: drop the valid once taken unless a new item arrives
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign read_data     = res_q.read_data;
	assign rumble_update = res_q.rumble_update;
	assign rumble_on     = res_q.rumble_on;

	a_on_needs_update: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.rumble_on |-> res_q.rumble_update)
		else $error("rumble level given without an update");

	a_empty_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input refused with an empty input register");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q)
		else $error("result dropped before it was taken");

	a_advance_frees: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_valid_q |-> in_ready)
		else $error("input stalled while the result register is free");

endmodule

### src/cgsr_port_core.sv
module cgsr_port_core
	import cgsr_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    clock_enable,
	input  logic    rumble_enable,
	input  logic    advance,
	input  item_t   item,
	output result_t result
);

	logic [7:0] pins_q, dir_q, rden_q, cmd_q, sc_q;
	logic [2:0] tb_q, strobe_q;
	logic [5:0] bc_q;
	phase_t     phase_q;
	logic [7:0] sbuf_q [8];

	logic [7:0] n_pins, n_dir, n_rden, n_cmd, n_sc;
	logic [2:0] n_tb, n_strobe;
	logic [5:0] n_bc;
	phase_t     n_phase;
	logic [7:0] n_sbuf [8];

	logic [15:0] tilt_v;
	logic [15:0] value;
	logic [7:0]  rd;
	logic [2:0]  idx;
	logic        bit_out;
	logic        upd, on;

	assign value  = item.write_value;
	assign tilt_v = TILT_OFFSET + item.tilt_z;
	assign idx    = bc_q[5:3];

	always_comb begin
		n_pins   = pins_q;
		n_dir    = dir_q;
		n_rden   = rden_q;
		n_cmd    = cmd_q;
		n_sc     = sc_q;
		n_tb     = tb_q;
		n_strobe = strobe_q;
		n_bc     = bc_q;
		n_phase  = phase_q;
		n_sbuf   = sbuf_q;
		rd       = '0;
		upd      = 1'b0;
		on       = 1'b0;
		bit_out  = sbuf_q[idx][bc_q[2:0]];

		if (item.op == OP_READ) begin
			case (item.reg_select)
				SEL_RDEN: rd = rden_q;
				SEL_DIR:  rd = dir_q;
				SEL_DATA: begin
					if (rden_q[0]) begin
						if (dir_q == DIR_LIGHT && sc_q >= item.light_level) begin
							rd[3] = 1'b1;
						end
						if (dir_q == DIR_TILT && sc_q < 8'd16) begin
							rd[2] = tilt_v[sc_q[3:0]];
						end
						if (clock_enable && dir_q[2]) begin
							rd = rd | pins_q;
						end
					end
				end
				default: rd = '0;
			endcase
		end else begin
			case (item.reg_select)
				SEL_RDEN: n_rden = value[7:0];
				SEL_DIR: begin
					n_dir = value[7:0];
					if (rumble_enable && !value[3]) begin
						upd = 1'b1;
					end
				end
				SEL_DATA: begin
					if (rumble_enable && dir_q[3]) begin
						upd = 1'b1;
						on  = value[3];
					end
					if (dir_q == DIR_LIGHT) begin
						if (value[1]) begin
							n_sc = '0;
						end
						if (value[0] && !strobe_q[0]) begin
							n_sc = n_sc + 8'd1;
						end
						n_strobe = value[2:0];
					end
					if (dir_q == DIR_TILT) begin
						if (value[1]) begin
							n_sc = n_sc - 8'd1;
						end
						if (value[0]) begin
							n_sc = 8'd15;
						end
						n_pins = value[7:0] & dir_q;
					end
					if (dir_q[2]) begin
						if (phase_q == PH_IDLE && n_pins == 8'd1 && value == CMD_START) begin
							n_phase = PH_CMD;
							n_bc    = '0;
							n_cmd   = '0;
						end else if (!n_pins[0] && value[0]) begin
							n_pins = value[7:0];
							case (phase_q)
								PH_CMD: begin
									n_cmd = cmd_q | (8'(value[1]) << (3'd7 - bc_q[2:0]));
									n_bc  = bc_q + 6'd1;
									if (n_bc == 6'd8) begin
										n_bc = '0;
										case (n_cmd)
											CMD_RESET: n_phase = PH_IDLE;
											CMD_WRITE: begin
												n_phase = PH_RECV;
												n_tb    = 3'd1;
											end
											CMD_STATUS: begin
												n_tb      = 3'd1;
												n_sbuf[0] = STATUS_BYTE;
												n_phase   = PH_SEND;
											end
											CMD_CONTINUE: n_phase = PH_CMD;
											CMD_DATETIME: begin
												n_tb      = 3'd7;
												n_sbuf[0] = bcd8(item.time_year);
												n_sbuf[1] = bcd8(8'(item.time_month) + 8'd1);
												n_sbuf[2] = bcd8(8'(item.time_day));
												n_sbuf[3] = bcd8(8'(item.time_weekday));
												n_sbuf[4] = bcd8(8'(item.time_hour));
												n_sbuf[5] = bcd8(8'(item.time_minute));
												n_sbuf[6] = bcd8(8'(item.time_second));
												n_phase   = PH_SEND;
											end
											CMD_TIME: begin
												n_tb      = 3'd3;
												n_sbuf[0] = bcd8(8'(item.time_hour));
												n_sbuf[1] = bcd8(8'(item.time_minute));
												n_sbuf[2] = bcd8(8'(item.time_second));
												n_phase   = PH_SEND;
											end
											default: n_phase = PH_IDLE;
										endcase
									end
								end
								PH_SEND: begin
									if (!dir_q[1]) begin
										n_pins[1] = bit_out;
										n_bc      = bc_q + 6'd1;
										if (n_bc == {n_tb, 3'b000}) begin
											n_bc    = '0;
											n_phase = PH_IDLE;
										end
									end
								end
								PH_RECV: begin
									if (dir_q[1]) begin
										n_sbuf[idx] = {value[1], sbuf_q[idx][7:1]};
										n_bc        = bc_q + 6'd1;
										if (n_bc == {n_tb, 3'b000}) begin
											n_bc    = '0;
											n_phase = PH_IDLE;
										end
									end
								end
								default: n_bc = bc_q;
							endcase
						end else begin
							n_pins = value[7:0];
						end
					end
				end
				default: n_rden = rden_q;
			endcase
		end
	end

	assign result = '{read_data: rd, rumble_update: upd, rumble_on: on};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pins_q   <= '0;
			dir_q    <= '0;
			rden_q   <= '0;
			cmd_q    <= '0;
			sc_q     <= '0;
			tb_q     <= '0;
			strobe_q <= '0;
			bc_q     <= '0;
			phase_q  <= PH_IDLE;
			for (int i = 0; i < 8; i++) begin
				sbuf_q[i] <= '0;
			end
		end else if (advance) begin
			pins_q   <= n_pins;
			dir_q    <= n_dir;
			rden_q   <= n_rden;
			cmd_q    <= n_cmd;
			sc_q     <= n_sc;
			tb_q     <= n_tb;
			strobe_q <= n_strobe;
			bc_q     <= n_bc;
			phase_q  <= n_phase;
			sbuf_q   <= n_sbuf;
		end
	end

	a_cmd_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_CMD |-> bc_q < 6'd8)
		else $error("command bit count past one byte");

	a_send_len: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_SEND || phase_q == PH_RECV) |-> tb_q != 3'd0)
		else $error("transfer started with no byte count");

	a_phase_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(phase_q))
		else $error("clock machine phase not one-hot");

endmodule
